@@ rtl/wasc_pkg.sv @@
`timescale 1ns / 1ps
package wasc_pkg;

	localparam int MAX_WINDOW = 32;
	localparam int MAP_W      = 32;
	localparam int WIN_CAP    = (MAX_WINDOW < MAP_W) ? MAX_WINDOW : MAP_W;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_ACK    = 2'd1;
	localparam logic [1:0] CMD_START  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] K_SEND = 2'd0;
	localparam logic [1:0] K_RETX = 2'd1;
	localparam logic [1:0] K_EOT  = 2'd2;

	localparam logic [2:0] REG_PACKET_COUNT = 3'd0;
	localparam logic [2:0] REG_INIT_WINDOW  = 3'd1;
	localparam logic [2:0] REG_ALPHA        = 3'd2;
	localparam logic [2:0] REG_BETA         = 3'd3;
	localparam logic [2:0] REG_MAX_TIMEOUT  = 3'd4;
	localparam logic [2:0] REG_INIT_EST     = 3'd5;
	localparam logic [2:0] REG_INIT_DEV     = 3'd6;

	typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_DONE} phase_t;

	typedef enum logic [2:0] {
		FS_IDLE, FS_EST_A, FS_EST_B, FS_DEV_A, FS_DEV_B, FS_RTO, FS_SEND
	} fstate_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [15:0]      base;
		logic [MAP_W-1:0] map;
		logic [5:0]       window;
		logic [15:0]      timeout;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} jq_status_t;

endpackage

@@ rtl/wasc_front.sv @@
`timescale 1ns / 1ps
module wasc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          command,
	input  logic [15:0]         ack_num,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  wasc_pkg::jq_status_t jq_status,
	output logic                job_push,
	output wasc_pkg::job_t      job
);
	import wasc_pkg::*;

	logic [15:0] packet_count_q, max_timeout_q, init_est_q;
	logic [5:0]  init_window_q;
	logic [8:0]  alpha_q, beta_q;
	logic [13:0] init_dev_q;

	fstate_t     state_q, state_d;
	phase_t      phase_q;
	logic [15:0] next_seq_q, base_q, est_q, dev_q, timeout_q, elapsed_q, sample_q;
	logic [MAP_W-1:0] map_q;
	logic [5:0]  window_q;
	logic        send_pend_q;
	logic [24:0] prod_q;

	logic        accept;
	logic [8:0]  a_c, b_c;
	logic [24:0] mul_a, mul_b, sum_c;
	logic [15:0] est_new, diff, elapsed_inc, off, sent;
	logic [16:0] remain;
	logic [18:0] rto_sum;
	logic [5:0]  n_send, win_init, win_half;
	logic [MAP_W-1:0] send_map, ack_map;
	logic        match, timeout_hit;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	assign a_c = (alpha_q > 9'd256) ? 9'd256 : alpha_q;
	assign b_c = (beta_q > 9'd256) ? 9'd256 : beta_q;

	always_comb begin
		mul_a = 25'(9'd256 - a_c) * 25'(est_q);
		mul_b = 25'(a_c) * 25'(sample_q);
		if (state_q == FS_DEV_A || state_q == FS_DEV_B) begin
			mul_a = 25'(9'd256 - b_c) * 25'(dev_q);
			mul_b = 25'(b_c) * 25'(diff);
		end
	end
	assign sum_c   = prod_q + mul_b;
	assign est_new = sum_c[23:8];
	assign diff    = (sample_q > est_q) ? sample_q - est_q : est_q - sample_q;
	assign rto_sum = 19'(est_q) + {1'b0, dev_q, 2'b00};

	assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
	assign timeout_hit = (elapsed_inc >= timeout_q) && (map_q != '0);
	assign off   = ack_num - base_q;
	assign match = (off < 16'(MAP_W)) && map_q[off[4:0]];
	always_comb begin
		ack_map = map_q;
		ack_map[off[4:0]] = 1'b0;
	end

	assign sent   = next_seq_q - 16'd1;
	assign remain = (packet_count_q > sent) ? 17'(packet_count_q - sent) : 17'd0;
	assign n_send = (remain < 17'(window_q)) ? remain[5:0] : window_q;
	always_comb begin
		for (int i = 0; i < MAP_W; i++)
			send_map[i] = (i < int'(n_send));
	end

	assign win_init = (init_window_q == 6'd0) ? 6'd1 :
		(init_window_q > 6'(WIN_CAP)) ? 6'(WIN_CAP) : init_window_q;
	assign win_half = (window_q[5:1] == 5'd0) ? 6'd1 : {1'b0, window_q[5:1]};

	always_comb begin
		state_d  = state_q;
		full     = 1'b1;
		job_push = 1'b0;
		job.kind    = K_RETX;
		job.base    = base_q;
		job.map     = map_q;
		job.window  = window_q;
		job.timeout = timeout_q;
		case (state_q)
			FS_IDLE: begin
				full = jq_status.full;
				if (accept) begin
					case (command)
						CMD_START: state_d = FS_RTO;
						CMD_ACK:   if (phase_q == PH_WAIT) state_d = FS_EST_A;
						CMD_TICK: begin
							if (phase_q == PH_WAIT && timeout_hit) begin
								job_push = 1'b1;
								state_d  = FS_EST_A;
							end
						end
						default: state_d = FS_IDLE;
					endcase
				end
			end
			FS_EST_A: state_d = FS_EST_B;
			FS_EST_B: state_d = FS_DEV_A;
			FS_DEV_A: state_d = FS_DEV_B;
			FS_DEV_B: state_d = FS_RTO;
			FS_RTO:   state_d = send_pend_q ? FS_SEND : FS_IDLE;
			FS_SEND: begin
				job_push = 1'b1;
				if (remain == 17'd0) begin
					job.kind = K_EOT;
					job.base = '0;
					job.map  = MAP_W'(1);
				end else begin
					job.kind = K_SEND;
					job.base = next_seq_q;
					job.map  = send_map;
				end
				state_d = FS_IDLE;
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FS_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_count_q <= 16'd0;
			init_window_q  <= 6'd4;
			alpha_q        <= 9'd32;
			beta_q         <= 9'd64;
			max_timeout_q  <= 16'd3000;
			init_est_q     <= 16'd500;
			init_dev_q     <= 14'd100;
			phase_q        <= PH_IDLE;
			next_seq_q     <= 16'd1;
			base_q         <= 16'd0;
			map_q          <= '0;
			window_q       <= 6'd4;
			est_q          <= 16'd500;
			dev_q          <= 16'd100;
			timeout_q      <= 16'd900;
			elapsed_q      <= 16'd0;
			sample_q       <= 16'd0;
			send_pend_q    <= 1'b0;
			prod_q         <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_PACKET_COUNT: packet_count_q <= cfg_data;
					REG_INIT_WINDOW:  init_window_q  <= cfg_data[5:0];
					REG_ALPHA:        alpha_q        <= cfg_data[8:0];
					REG_BETA:         beta_q         <= cfg_data[8:0];
					REG_MAX_TIMEOUT:  max_timeout_q  <= cfg_data;
					REG_INIT_EST:     init_est_q     <= cfg_data;
					REG_INIT_DEV:     init_dev_q     <= cfg_data[13:0];
					default: ;
				endcase
			end
			case (state_q)
				FS_IDLE: begin
					if (accept) begin
						case (command)
							CMD_START: begin
								window_q    <= win_init;
								est_q       <= init_est_q;
								dev_q       <= {2'b00, init_dev_q};
								next_seq_q  <= 16'd1;
								base_q      <= 16'd0;
								map_q       <= '0;
								elapsed_q   <= 16'd0;
								send_pend_q <= 1'b1;
							end
							CMD_ACK: begin
								if (phase_q == PH_WAIT) begin
									sample_q    <= elapsed_q;
									send_pend_q <= 1'b0;
									if (match) begin
										map_q <= ack_map;
										if (window_q < 6'(WIN_CAP))
											window_q <= window_q + 6'd1;
										send_pend_q <= (ack_map == '0);
									end
								end
							end
							CMD_TICK: begin
								if (phase_q == PH_WAIT) begin
									elapsed_q <= elapsed_inc;
									if (timeout_hit) begin
										sample_q    <= elapsed_inc;
										elapsed_q   <= 16'd0;
										window_q    <= win_half;
										send_pend_q <= 1'b0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				FS_EST_A: prod_q <= mul_a;
				FS_EST_B: est_q  <= est_new;
				FS_DEV_A: prod_q <= mul_a;
				FS_DEV_B: dev_q  <= est_new;
				FS_RTO: timeout_q <= (rto_sum < 19'(max_timeout_q)) ? rto_sum[15:0] : max_timeout_q;
				FS_SEND: begin
					if (remain == 17'd0) begin
						map_q   <= '0;
						phase_q <= PH_DONE;
					end else begin
						base_q     <= next_seq_q;
						map_q      <= send_map;
						next_seq_q <= next_seq_q + 16'(n_send);
						elapsed_q  <= 16'd0;
						phase_q    <= PH_WAIT;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/wasc_jobq.sv @@
`timescale 1ns / 1ps
module wasc_jobq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  wasc_pkg::job_t       wr_job,
	input  logic                 rd,
	output wasc_pkg::job_t       rd_job,
	output wasc_pkg::jq_status_t status
);
	import wasc_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

@@ rtl/wasc_back.sv @@
`timescale 1ns / 1ps
module wasc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wasc_pkg::jq_status_t jq_status,
	input  wasc_pkg::job_t       jq_job,
	output logic                 jq_rd,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           kind,
	output logic [15:0]          seq_num,
	output logic [5:0]           window_now,
	output logic [15:0]          timeout_now,
	output logic                 last
);
	import wasc_pkg::*;

	logic             busy_q, ovalid_q;
	job_t             job_q;
	logic [MAP_W-1:0] rem_q;
	logic [4:0]       off_q;
	logic             adv, is_last;

	assign empty   = !ovalid_q;
	assign adv     = busy_q && (!ovalid_q || pop);
	assign is_last = (rem_q[MAP_W-1:1] == '0);
	assign jq_rd   = !busy_q && !jq_status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ovalid_q    <= 1'b0;
			job_q       <= '0;
			rem_q       <= '0;
			off_q       <= '0;
			kind        <= K_SEND;
			seq_num     <= 16'd0;
			window_now  <= 6'd0;
			timeout_now <= 16'd0;
			last        <= 1'b0;
		end else begin
			if (pop && ovalid_q) ovalid_q <= 1'b0;
			if (jq_rd) begin
				busy_q <= 1'b1;
				job_q  <= jq_job;
				rem_q  <= jq_job.map;
				off_q  <= '0;
			end else if (adv) begin
				rem_q <= rem_q >> 1;
				off_q <= off_q + 5'd1;
				if (rem_q[0]) begin
					ovalid_q    <= 1'b1;
					kind        <= job_q.kind;
					seq_num     <= job_q.base + 16'(off_q);
					window_now  <= job_q.window;
					timeout_now <= job_q.timeout;
					last        <= is_last;
				end
				if (is_last) busy_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/window_arq_sender_controller_core.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// input     in         push / full          command, ack_num
// result    out        empty / pop          kind, seq_num, window_now, timeout_now, last
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
// a plain tick is taken in idle; an ack in the wait phase or a timeout tick runs four
// steps of the shared rtt multiplier and the timeout clamp, plus the send state when a
// window goes out; a start runs the clamp and the send state; full stays high while busy
// the back scans one map bit per cycle and fills the output when it is free or popped
// reset clears all control state and loads the register defaults; no clearing pass
// input and output stall independently through a two-entry job queue
module window_arq_sender_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [15:0] ack_num,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [15:0] seq_num,
	output logic [5:0]  window_now,
	output logic [15:0] timeout_now,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import wasc_pkg::*;

	jq_status_t jq_status;
	job_t       wr_job, rd_job;
	logic       job_push, jq_rd;

	wasc_front u_front (
		.clk, .arst_n, .push, .full, .command, .ack_num,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.jq_status, .job_push, .job(wr_job)
	);

	wasc_jobq u_jobq (
		.clk, .arst_n, .wr(job_push), .wr_job, .rd(jq_rd), .rd_job, .status(jq_status)
	);

	wasc_back u_back (
		.clk, .arst_n, .jq_status, .jq_job(rd_job), .jq_rd, .empty, .pop,
		.kind, .seq_num, .window_now, .timeout_now, .last
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !(jq_status.full && !jq_rd))
		else $error("job queue overflow");

	a_eot_form: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == K_EOT) |-> (seq_num == 16'd0 && last))
		else $error("malformed end of transfer");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		jq_rd |-> !jq_status.empty)
		else $error("job queue underflow");

	a_window_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (window_now != 6'd0 && window_now <= 6'(WIN_CAP)))
		else $error("window out of range");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import wasc_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] seq;
		logic [5:0]  window;
		logic [15:0] timeout;
		logic        last;
	} packet_event_t;

	class arq_scoreboard;
		bit [15:0] packet_count = 0;
		bit [5:0]  init_window = 4;
		bit [8:0]  alpha = 32;
		bit [8:0]  beta = 64;
		bit [15:0] max_timeout = 3000;
		bit [15:0] init_est = 500;
		bit [13:0] init_dev = 100;
		phase_t    phase = PH_IDLE;
		int unsigned next_seq, window_base, map, window_size;
		int unsigned est_rtt, dev_rtt, timeout_ms, elapsed_ms;
		packet_event_t pending[$];
		int mismatches = 0;

		function new();
			reload();
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] v);
			case (idx)
				REG_PACKET_COUNT: packet_count = v;
				REG_INIT_WINDOW:  init_window = v[5:0];
				REG_ALPHA:        alpha = v[8:0];
				REG_BETA:         beta = v[8:0];
				REG_MAX_TIMEOUT:  max_timeout = v;
				REG_INIT_EST:     init_est = v;
				REG_INIT_DEV:     init_dev = v[13:0];
				default: ;
			endcase
		endfunction

		function void refresh_timeout();
			int unsigned t;
			t = est_rtt + 4 * dev_rtt;
			timeout_ms = (t < max_timeout) ? t : max_timeout;
		endfunction

		function void reload();
			window_size = (init_window == 0) ? 1 : init_window;
			if (window_size > WIN_CAP) window_size = WIN_CAP;
			est_rtt = init_est;
			dev_rtt = init_dev;
			refresh_timeout();
			next_seq = 1;
			window_base = 0;
			map = 0;
			elapsed_ms = 0;
		endfunction

		function void refresh_rtt();
			int unsigned a, b, d;
			a = (alpha > 256) ? 256 : alpha;
			b = (beta > 256) ? 256 : beta;
			est_rtt = ((256 - a) * est_rtt + a * elapsed_ms) >> 8;
			d = (elapsed_ms > est_rtt) ? elapsed_ms - est_rtt : est_rtt - elapsed_ms;
			dev_rtt = ((256 - b) * dev_rtt + b * d) >> 8;
			refresh_timeout();
		endfunction

		function void add(logic [1:0] k, int unsigned s);
			packet_event_t e;
			e.kind = k;
			e.seq = s[15:0];
			e.window = window_size[5:0];
			e.timeout = timeout_ms[15:0];
			e.last = 0;
			pending.push_back(e);
		endfunction

		function void send_window();
			int unsigned sent, remain, n;
			sent = (next_seq - 1) & 16'hffff;
			remain = (packet_count > sent) ? packet_count - sent : 0;
			if (remain == 0) begin
				add(K_EOT, 0);
				map = 0;
				phase = PH_DONE;
				return;
			end
			n = (window_size > remain) ? remain : window_size;
			if (n > 32) n = 32;
			if (n == 0) n = 1;
			window_base = next_seq;
			map = (n >= 32) ? 32'hffffffff : ((32'd1 << n) - 1);
			for (int i = 0; i < n; i++) begin
				add(K_SEND, next_seq);
				next_seq = (next_seq + 1) & 16'hffff;
			end
			elapsed_ms = 0;
			phase = PH_WAIT;
		endfunction

		function void note_input(logic [1:0] cmd, logic [15:0] ack);
			int prev_size;
			int unsigned off;
			prev_size = pending.size();
			if (cmd == CMD_START) begin
				reload();
				send_window();
			end else if (cmd == CMD_TICK && phase == PH_WAIT) begin
				if (elapsed_ms < 16'hffff) elapsed_ms++;
				if (elapsed_ms >= timeout_ms && map != 0) begin
					for (int i = 0; i < 32; i++)
						if (map[i]) add(K_RETX, (window_base + i) & 16'hffff);
					refresh_rtt();
					elapsed_ms = 0;
					window_size = window_size >> 1;
					if (window_size == 0) window_size = 1;
				end
			end else if (cmd == CMD_ACK && phase == PH_WAIT) begin
				off = (ack - window_base) & 16'hffff;
				refresh_rtt();
				if (off < 32 && map[off]) begin
					map[off] = 0;
					if (window_size < WIN_CAP) window_size++;
					if (map == 0) send_window();
				end
			end
			if (pending.size() > prev_size) pending[pending.size() - 1].last = 1;
		endfunction

		function void check_result(packet_event_t got);
			packet_event_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d seq=%0d", got.kind, got.seq);
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind || got.seq !== want.seq || got.window !== want.window
				|| got.timeout !== want.timeout || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp k=%0d s=%0d w=%0d t=%0d l=%0d got k=%0d s=%0d w=%0d t=%0d l=%0d",
						want.kind, want.seq, want.window, want.timeout, want.last,
						got.kind, got.seq, got.window, got.timeout, got.last);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [1:0] command = CMD_TICK;
	logic [15:0] ack_num = 0;
	logic empty;
	logic pop = 0;
	logic [1:0] kind;
	logic [15:0] seq_num;
	logic [5:0] window_now;
	logic [15:0] timeout_now;
	logic last;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [15:0] cfg_data = 0;

	arq_scoreboard board = new();
	int idle_cycles = 0;
	bit timed_out = 0;

	window_arq_sender_controller_core dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		packet_event_t got;
		if (arst_n) begin
			if (push && !full) board.note_input(command, ack_num);
			if (pop && !empty) begin
				got.kind = kind;
				got.seq = seq_num;
				got.window = window_now;
				got.timeout = timeout_now;
				got.last = last;
				board.check_result(got);
			end
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > 20000) timed_out = 1;
		end
	end

	// receiver stall pattern, with calm stretches
	int rx_phase = 0;
	always @(negedge clk) begin
		rx_phase = (rx_phase + 1) % 300;
		if (rx_phase < 80) pop <= 1;
		else pop <= ($urandom_range(0, 99) < 60);
	end

	int burst_left = 0;

	task automatic write_reg(logic [2:0] idx, logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// push stays high between items of a burst; gaps and drain lower it
	task automatic send_item(logic [1:0] cmd, logic [15:0] ack);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				push <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		push <= 1;
		command <= cmd;
		ack_num <= ack;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// mostly acks for outstanding numbers, some ticks, strays and restarts
	task automatic random_item();
		int r;
		int unsigned bit_i;
		r = $urandom_range(0, 99);
		if (r < 2) send_item(CMD_START, 16'($urandom));
		else if (r < 4) send_item(CMD_UNUSED, 16'($urandom));
		else if (r < 30) send_item(CMD_TICK, 16'($urandom));
		else if (r < 40) send_item(CMD_ACK, 16'($urandom));
		else if (board.map != 0) begin
			do bit_i = $urandom_range(0, 31); while (!board.map[bit_i]);
			send_item(CMD_ACK, 16'(board.window_base + bit_i));
		end else send_item(CMD_START, 16'($urandom));
	endtask

	task automatic set_all(int pc, int w, int a, int b, int mt, int e, int d);
		write_reg(REG_PACKET_COUNT, 16'(pc));
		write_reg(REG_INIT_WINDOW, 16'(w));
		write_reg(REG_ALPHA, 16'(a));
		write_reg(REG_BETA, 16'(b));
		write_reg(REG_MAX_TIMEOUT, 16'(mt));
		write_reg(REG_INIT_EST, 16'(e));
		write_reg(REG_INIT_DEV, 16'(d));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed
		send_item(CMD_TICK, 16'd0);
		send_item(CMD_ACK, 16'hffff);
		send_item(CMD_START, 16'd0);
		send_item(CMD_ACK, 16'd1);
		drain();
		set_all(3, 0, 256, 0, 1, 0, 0);
		send_item(CMD_START, 16'd0);
		send_item(CMD_TICK, 16'd0);
		send_item(CMD_ACK, 16'd3);
		send_item(CMD_ACK, 16'd2);
		send_item(CMD_ACK, 16'd1);
		send_item(CMD_ACK, 16'd1);
		drain();
		set_all(70, 63, 511, 511, 65535, 65535, 16383);
		send_item(CMD_START, 16'd0);
		send_item(CMD_ACK, 16'h0000);
		send_item(CMD_UNUSED, 16'hffff);
		for (int i = 1; i <= 32; i++) send_item(CMD_ACK, 16'(i));
		drain();
		set_all(0, 32, 0, 256, 100, 10, 5);
		send_item(CMD_START, 16'haaaa);
		send_item(CMD_TICK, 16'h5555);
		drain();
		set_all(40, 4, 32, 64, 20, 5, 2);
		send_item(CMD_START, 16'd0);
		for (int i = 0; i < 8; i++) send_item(CMD_TICK, 16'd0);
		drain();
		// random phases through several settings
		for (int p = 0; p < 5; p++) begin
			set_all($urandom_range(0, 60), $urandom_range(0, 63), $urandom_range(0, 511),
				$urandom_range(0, 511), $urandom_range(1, 40), $urandom_range(0, 30),
				$urandom_range(0, 10));
			send_item(CMD_START, 16'd0);
			for (int i = 0; i < 40; i++) random_item();
			drain();
		end
		if (board.pending.size() != 0) board.mismatches++;
		if (board.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		wait (timed_out);
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
